FILE: hw/rtl/vr2d_pkg.sv
// Package for the 2D vector rotation core: widths, fixed-point constants,
// payload structs and the CORDIC arctangent table. No dependencies.
package vr2d_pkg;

  localparam int COORD_WIDTH   = 24;
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES  = 24;
  localparam int NUM_STAGES    = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

  localparam int ANGLE_WIDTH   = 16;
  localparam int FULL_TURN     = 23040;
  localparam int RED_WIDTH     = 15;
  localparam int TURN_DIV      = 45;
  localparam int RECIP_DIV     = 11651;
  localparam int RECIP_WIDTH   = 14;
  localparam int RECIP_SHIFT   = 19;
  localparam int RPROD_WIDTH   = RED_WIDTH + RECIP_WIDTH;
  localparam int QUO_WIDTH     = 9;
  localparam int REM_WIDTH     = 6;
  localparam int FRAC_WIDTH    = 23;
  localparam int FRAC_STEP     = 186413;
  localparam int FPROD_WIDTH   = REM_WIDTH + 18;
  localparam int Z_WIDTH       = QUO_WIDTH + FRAC_WIDTH;

  localparam int GUARD_BITS    = 16;
  localparam int GAIN_Q        = 30;
  localparam int GAIN_WIDTH    = 31;
  localparam int PRESHIFT      = GAIN_Q - GUARD_BITS;
  localparam int NEG_WIDTH     = COORD_WIDTH + 1;
  localparam int ACC_WIDTH     = COORD_WIDTH + GUARD_BITS + 3;
  localparam int PROD_WIDTH    = PRESHIFT + ACC_WIDTH;
  localparam int RND_WIDTH     = ACC_WIDTH - GUARD_BITS;

  localparam logic signed [GAIN_WIDTH-1:0] GAIN_K = GAIN_WIDTH'(652032874);

  localparam int ANGLE_STAGES  = 4;
  localparam int PIPE_DEPTH    = ANGLE_STAGES + 1 + NUM_STAGES + 1;

  localparam int IN_BITS       = 2 * COORD_WIDTH + ANGLE_WIDTH;
  localparam int IN_DATA_WIDTH = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS      = 2 * COORD_WIDTH;
  localparam int OUT_DATA_WIDTH = ((OUT_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic signed [NEG_WIDTH-1:0] x;
    logic signed [NEG_WIDTH-1:0] y;
    logic signed [Z_WIDTH-1:0]   z;
  } quad_t;

  typedef struct packed {
    logic signed [ACC_WIDTH-1:0] x;
    logic signed [ACC_WIDTH-1:0] y;
    logic signed [Z_WIDTH-1:0]   z;
  } acc_t;

  function automatic logic signed [Z_WIDTH-1:0] atan_value(input int i);
    logic signed [Z_WIDTH-1:0] v;
    case (i)
      0:       v = 32'sd536870912;
      1:       v = 32'sd316933406;
      2:       v = 32'sd167458907;
      3:       v = 32'sd85004756;
      4:       v = 32'sd42667331;
      5:       v = 32'sd21354465;
      6:       v = 32'sd10679838;
      7:       v = 32'sd5340245;
      8:       v = 32'sd2670163;
      9:       v = 32'sd1335087;
      10:      v = 32'sd667544;
      11:      v = 32'sd333772;
      12:      v = 32'sd166886;
      13:      v = 32'sd83443;
      14:      v = 32'sd41722;
      15:      v = 32'sd20861;
      16:      v = 32'sd10430;
      17:      v = 32'sd5215;
      18:      v = 32'sd2608;
      19:      v = 32'sd1304;
      20:      v = 32'sd652;
      21:      v = 32'sd326;
      22:      v = 32'sd163;
      23:      v = 32'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: hw/rtl/vr2d_angle.sv
// Angle front end: reduce modulo a full turn, convert to a binary angle,
// fold into [-90, 90) degrees, negating the vector when folded. Uses vr2d_pkg.
module vr2d_angle (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic signed [vr2d_pkg::COORD_WIDTH-1:0]   x_in,
  input  logic signed [vr2d_pkg::COORD_WIDTH-1:0]   y_in,
  input  logic signed [vr2d_pkg::ANGLE_WIDTH-1:0]   angle,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output vr2d_pkg::quad_t                           out_data
);

  localparam int AW = vr2d_pkg::ANGLE_WIDTH + 1;
  localparam logic signed [AW-1:0] TURN  = AW'(vr2d_pkg::FULL_TURN);
  localparam logic signed [AW-1:0] NTURN = -TURN;

  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3;

  logic signed [vr2d_pkg::COORD_WIDTH-1:0] x1, y1, x2, y2, x3, y3;
  logic [vr2d_pkg::RED_WIDTH-1:0]   r1, r2;
  logic [vr2d_pkg::QUO_WIDTH-1:0]   q2, q3;
  logic [vr2d_pkg::REM_WIDTH-1:0]   m3;

  logic signed [AW-1:0]                a_ext, r_next;
  logic [vr2d_pkg::RPROD_WIDTH-1:0]    rprod;
  logic [vr2d_pkg::RED_WIDTH-1:0]      m_full;
  logic [vr2d_pkg::FPROD_WIDTH-1:0]    fprod;
  logic [vr2d_pkg::Z_WIDTH-1:0]        theta;
  logic                                neg;
  vr2d_pkg::quad_t                     quad_next;

  assign rdy3     = !v4 || out_ready;
  assign rdy2     = !v3 || rdy3;
  assign rdy1     = !v2 || rdy2;
  assign in_ready = !v1 || rdy1;

  always_comb begin
    a_ext = AW'(angle);
    if (a_ext < NTURN) begin
      r_next = a_ext + TURN + TURN;
    end else if (a_ext < 0) begin
      r_next = a_ext + TURN;
    end else if (a_ext >= TURN) begin
      r_next = a_ext - TURN;
    end else begin
      r_next = a_ext;
    end
  end

  assign rprod  = vr2d_pkg::RPROD_WIDTH'(r1)
                * vr2d_pkg::RPROD_WIDTH'(vr2d_pkg::RECIP_DIV);
  assign m_full = r2 - vr2d_pkg::RED_WIDTH'(vr2d_pkg::QUO_WIDTH'(q2)
                * vr2d_pkg::RED_WIDTH'(vr2d_pkg::TURN_DIV));
  assign fprod  = vr2d_pkg::FPROD_WIDTH'(m3) * vr2d_pkg::FPROD_WIDTH'(vr2d_pkg::FRAC_STEP)
                + (vr2d_pkg::FPROD_WIDTH'((vr2d_pkg::REM_WIDTH + 1)'(m3) + 1'b1) >> 1);

  always_comb begin
    theta = {q3, fprod[vr2d_pkg::FRAC_WIDTH-1:0]};
    neg   = q3[vr2d_pkg::QUO_WIDTH-1] ^ q3[vr2d_pkg::QUO_WIDTH-2];
    if (neg) begin
      quad_next.x = -vr2d_pkg::NEG_WIDTH'(x3);
      quad_next.y = -vr2d_pkg::NEG_WIDTH'(y3);
      quad_next.z = {~theta[vr2d_pkg::Z_WIDTH-1], theta[vr2d_pkg::Z_WIDTH-2:0]};
    end else begin
      quad_next.x = vr2d_pkg::NEG_WIDTH'(x3);
      quad_next.y = vr2d_pkg::NEG_WIDTH'(y3);
      quad_next.z = theta;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (in_ready) v1 <= in_valid;
      if (rdy1)     v2 <= v1;
      if (rdy2)     v3 <= v2;
      if (rdy3)     v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      x1 <= x_in;
      y1 <= y_in;
      r1 <= r_next[vr2d_pkg::RED_WIDTH-1:0];
    end
    if (rdy1) begin
      x2 <= x1;
      y2 <= y1;
      r2 <= r1;
      q2 <= rprod[vr2d_pkg::RECIP_SHIFT +: vr2d_pkg::QUO_WIDTH];
    end
    if (rdy2) begin
      x3 <= x2;
      y3 <= y2;
      q3 <= q2;
      m3 <= m_full[vr2d_pkg::REM_WIDTH-1:0];
    end
    if (rdy3) begin
      out_data <= quad_next;
    end
  end

  assign out_valid = v4;

endmodule

FILE: hw/rtl/vr2d_prescale.sv
// Gain compensation stage: multiply both coordinates by K and keep the guard
// fraction bits. Uses vr2d_pkg.
module vr2d_prescale (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  vr2d_pkg::quad_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output vr2d_pkg::acc_t   out_data
);

  logic valid;
  logic signed [vr2d_pkg::PROD_WIDTH-1:0] px, py;

  assign in_ready = !valid || out_ready;

  assign px = in_data.x * vr2d_pkg::GAIN_K;
  assign py = in_data.y * vr2d_pkg::GAIN_K;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_data.x <= px[vr2d_pkg::PRESHIFT +: vr2d_pkg::ACC_WIDTH];
      out_data.y <= py[vr2d_pkg::PRESHIFT +: vr2d_pkg::ACC_WIDTH];
      out_data.z <= in_data.z;
    end
  end

  assign out_valid = valid;

endmodule

FILE: hw/rtl/vr2d_cordic.sv
// CORDIC rotation pipeline: one registered micro-rotation per stage.
// Uses vr2d_pkg for widths and the arctangent table.
module vr2d_cordic (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  vr2d_pkg::acc_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output vr2d_pkg::acc_t   out_data
);

  localparam int N = vr2d_pkg::NUM_STAGES;

  vr2d_pkg::acc_t stage [0:N];
  logic           vld   [0:N];
  logic           rdy   [0:N];

  assign stage[0] = in_data;
  assign vld[0]   = in_valid;
  assign rdy[N]   = out_ready;
  assign in_ready = rdy[0];

  for (genvar i = 0; i < N; i++) begin : g_stage
    vr2d_pkg::acc_t nxt;
    logic signed [vr2d_pkg::ACC_WIDTH-1:0] xs, ys;

    assign rdy[i] = !vld[i+1] || rdy[i+1];
    assign xs = stage[i].x >>> i;
    assign ys = stage[i].y >>> i;

    always_comb begin
      if (!stage[i].z[vr2d_pkg::Z_WIDTH-1]) begin
        nxt.x = stage[i].x - ys;
        nxt.y = stage[i].y + xs;
        nxt.z = stage[i].z - vr2d_pkg::atan_value(i);
      end else begin
        nxt.x = stage[i].x + ys;
        nxt.y = stage[i].y - xs;
        nxt.z = stage[i].z + vr2d_pkg::atan_value(i);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (rdy[i]) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i]) begin
        stage[i+1] <= nxt;
      end
    end
  end

  assign out_data  = stage[N];
  assign out_valid = vld[N];

endmodule

FILE: hw/rtl/vr2d_output.sv
// Output stage: round half up, dropping the 16 guard fraction bits, and saturate to the
// coordinate range. Uses vr2d_pkg.
module vr2d_output (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  vr2d_pkg::acc_t                           in_data,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [vr2d_pkg::COORD_WIDTH-1:0]  x_out,
  output logic signed [vr2d_pkg::COORD_WIDTH-1:0]  y_out
);

  localparam int CW = vr2d_pkg::COORD_WIDTH;
  localparam int RW = vr2d_pkg::RND_WIDTH;
  localparam logic signed [vr2d_pkg::ACC_WIDTH-1:0] HALF =
    vr2d_pkg::ACC_WIDTH'(1) <<< (vr2d_pkg::GUARD_BITS - 1);
  localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

  logic valid;
  logic signed [vr2d_pkg::ACC_WIDTH-1:0] sx, sy;
  logic signed [RW-1:0] rx, ry;
  logic signed [CW-1:0] cx, cy;

  assign in_ready = !valid || out_ready;

  assign sx = in_data.x + HALF;
  assign sy = in_data.y + HALF;
  assign rx = sx[vr2d_pkg::ACC_WIDTH-1:vr2d_pkg::GUARD_BITS];
  assign ry = sy[vr2d_pkg::ACC_WIDTH-1:vr2d_pkg::GUARD_BITS];

  always_comb begin
    if (rx[RW-1:CW-1] == '0 || rx[RW-1:CW-1] == '1) begin
      cx = rx[CW-1:0];
    end else begin
      cx = rx[RW-1] ? MINV : MAXV;
    end
    if (ry[RW-1:CW-1] == '0 || ry[RW-1:CW-1] == '1) begin
      cy = ry[CW-1:0];
    end else begin
      cy = ry[RW-1] ? MINV : MAXV;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      x_out <= cx;
      y_out <= cy;
    end
  end

  assign out_valid = valid;

endmodule

FILE: hw/rtl/vector_rotate_2d_core.sv
// Top level of the 2D vector rotation core: stream ports, angle front end,
// gain prescale, CORDIC pipeline and output rounding. Uses vr2d_pkg.
// Registered stages from input accept to m_tvalid: 4 angle, 1 prescale,
// 16 CORDIC, 1 output; one item per cycle while m_tready is high.
// Each stage holds while its successor is full and stalled; bubbles collapse.
// Synchronous reset clears all valid bits; the pipeline is empty after reset.
module vector_rotate_2d_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // x_in [23:0], y_in [47:24], angle [63:48]
  input  logic [vr2d_pkg::IN_DATA_WIDTH-1:0]     s_tdata,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // x_out [23:0], y_out [47:24]
  output logic [vr2d_pkg::OUT_DATA_WIDTH-1:0]    m_tdata
);

  localparam int CW = vr2d_pkg::COORD_WIDTH;

  logic                 ang_valid, ang_ready;
  logic                 pre_valid, pre_ready;
  logic                 cor_valid, cor_ready;
  vr2d_pkg::quad_t      ang_data;
  vr2d_pkg::acc_t       pre_data, cor_data;
  logic signed [CW-1:0] x_out, y_out;

  vr2d_angle u_angle (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .x_in      (s_tdata[CW-1:0]),
    .y_in      (s_tdata[2*CW-1:CW]),
    .angle     (s_tdata[2*CW +: vr2d_pkg::ANGLE_WIDTH]),
    .out_valid (ang_valid),
    .out_ready (ang_ready),
    .out_data  (ang_data)
  );

  vr2d_prescale u_prescale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ang_valid),
    .in_ready  (ang_ready),
    .in_data   (ang_data),
    .out_valid (pre_valid),
    .out_ready (pre_ready),
    .out_data  (pre_data)
  );

  vr2d_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pre_valid),
    .in_ready  (pre_ready),
    .in_data   (pre_data),
    .out_valid (cor_valid),
    .out_ready (cor_ready),
    .out_data  (cor_data)
  );

  vr2d_output u_output (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cor_valid),
    .in_ready  (cor_ready),
    .in_data   (cor_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .x_out     (x_out),
    .y_out     (y_out)
  );

  assign m_tdata = vr2d_pkg::OUT_DATA_WIDTH'({y_out, x_out});

endmodule

FILE: hw/rtl/vr2d_checker.sv
// Port-level checker for vector_rotate_2d_core, attached with a bind.
// Tracks items in flight against the pipeline depth. Uses vr2d_pkg.
module vr2d_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  input  logic                                s_tready,
  input  logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic [vr2d_pkg::OUT_DATA_WIDTH-1:0] m_tdata
);

  localparam int CNTW = $clog2(vr2d_pkg::PIPE_DEPTH + 2);

  logic [CNTW-1:0] inflight;
  logic            s_acc, m_acc;

  assign s_acc = s_tvalid && s_tready;
  assign m_acc = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else if (s_acc && !m_acc) begin
      inflight <= inflight + 1'b1;
    end else if (m_acc && !s_acc) begin
      inflight <= inflight - 1'b1;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result item changed while stalled");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    inflight <= CNTW'(vr2d_pkg::PIPE_DEPTH))
    else $error("more items in flight than pipeline stages");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> inflight != '0)
    else $error("result item with no input item in flight");

  a_flow: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while output side is ready");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result item shown right after reset");

endmodule

bind vector_rotate_2d_core vr2d_checker u_vr2d_checker (.*);
